/* sv/els_pkg.sv */
// Shared types and constants for the LOOK elevator scheduler.
`default_nettype none
package els_pkg;

	localparam int FLOOR_W = 7;
	localparam int IDX_W   = 8;
	localparam int OUT_W   = 16;

	localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 7'd80;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_REMOVED   = 3'd1,
		ST_OUT_RANGE = 3'd2,
		ST_EXIT      = 3'd3,
		ST_ARRIVED   = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic press;
		logic scan_init;
		logic scan_step;
		logic scan_flip;
		logic take;
		logic miss;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run;
		logic in_range;
		logic hit;
		logic second;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* sv/elevator_look_scheduler_top.sv */
// Top level of the LOOK elevator scheduler.
//
//  channel  dir  signals                          contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  floor_number, func
//  m_*      out  m_tvalid m_tready m_tdata          status, current_floor_out, going_up
//  cfg_*    in   cfg_we cfg_wdata                  top_floor
//
// A press item goes through accept, evaluate and load output.
// A run item goes through accept, evaluate, a scan that examines one floor per cycle and
// turns round once if the first direction is found empty, and load output.
// Reset clears all request bits at once, puts the car on floor 1 going up, top_floor 80.
// A result waits in the output register; the next item is accepted meanwhile and is
// held in its last cycle until that register is free.
`default_nettype none
module elevator_look_scheduler_top #(
	parameter int MAX_FLOORS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [6:0] floor_number, [7] zero
	input  wire logic        s_tuser,   // [0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [2:0] status, [9:3] current_floor_out, [10] going_up
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata  // top_floor
);
	import els_pkg::*;

	cmd_t cmd;
	sts_t sts;

	els_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	els_dp #(
		.MAX_FLOORS (MAX_FLOORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= ST_NONE))
		else $error("undefined status code");

	a_floor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:3] != 7'd0))
		else $error("car reported on floor zero");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire

/* sv/els_ctrl.sv */
// Controller state machine of the LOOK elevator scheduler.
`default_nettype none
module els_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  els_pkg::sts_t      sts,
	output els_pkg::cmd_t      cmd
);
	import els_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		EVAL,
		SCAN,
		EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid && ready_q) begin
					cmd.load = 1'b1;
					state_d  = EVAL;
				end
			end
			EVAL: begin
				if (sts.run) begin
					cmd.scan_init = 1'b1;
					state_d       = SCAN;
				end else begin
					cmd.press = 1'b1;
					state_d   = EMIT;
				end
			end
			SCAN: begin
				if (!sts.in_range) begin
					// The first direction is exhausted: turn round once, then give up.
					if (sts.second) begin
						cmd.miss = 1'b1;
						state_d  = EMIT;
					end else begin
						cmd.scan_flip = 1'b1;
					end
				end else if (sts.hit) begin
					cmd.take = 1'b1;
					state_d  = EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == IDLE);
		end
	end

	assign s_tready = ready_q;

endmodule
`default_nettype wire

/* sv/els_dp.sv */
// Datapath of the LOOK elevator scheduler: request bits, car state, scan counter, output register.
`default_nettype none
module els_dp #(
	parameter int MAX_FLOORS = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tuser,
	input  wire logic [7:0]                    s_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [els_pkg::FLOOR_W-1:0]   cfg_wdata,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic [els_pkg::OUT_W-1:0]          m_tdata,
	input  els_pkg::cmd_t                      cmd,
	output els_pkg::sts_t                      sts
);
	import els_pkg::*;

	// Floor numbers never exceed 127, so no more request bits are ever reachable.
	localparam int NUM_BITS = (MAX_FLOORS < 128) ? MAX_FLOORS : 128;
	localparam int IW       = $clog2(NUM_BITS);
	localparam logic [IDX_W-1:0] NUM_B = IDX_W'(NUM_BITS);

	logic [NUM_BITS-1:0] req_q;
	logic [FLOOR_W-1:0]  car_q;
	logic                dir_q;
	logic [FLOOR_W-1:0]  top_q;
	logic [IDX_W-1:0]    idx_q;
	logic                sdir_q;
	logic                pass_q;
	logic                out_valid_q;
	logic                item_func_q;
	logic [FLOOR_W-1:0]  item_fl_q;
	status_t             res_status_q;
	logic [OUT_W-1:0]    out_data_q;

	logic [IDX_W-1:0]    fl_ext;
	logic [IDX_W-1:0]    rd_idx;
	logic                rd_bit;
	logic                fl_ok;
	logic [IDX_W-1:0]    up_init;
	logic [IDX_W-1:0]    dn_init;
	logic                in_range;

	assign fl_ext  = {1'b0, item_fl_q};
	assign rd_idx  = item_func_q ? idx_q : fl_ext;
	assign rd_bit  = (rd_idx < NUM_B) && req_q[rd_idx[IW-1:0]];
	assign fl_ok   = (item_fl_q != '0) && (item_fl_q <= top_q) && (fl_ext < NUM_B);
	assign up_init = {1'b0, car_q} + IDX_W'(1);
	assign dn_init = {1'b0, car_q} - IDX_W'(1);
	assign in_range = sdir_q ? ((idx_q <= {1'b0, top_q}) && (idx_q < NUM_B))
	                         : (idx_q != '0);

	assign sts.run      = item_func_q;
	assign sts.in_range = in_range;
	assign sts.hit      = rd_bit;
	assign sts.second   = pass_q;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= '0;
			car_q       <= FLOOR_W'(1);
			dir_q       <= 1'b1;
			top_q       <= TOP_FLOOR_RESET;
			idx_q       <= '0;
			sdir_q      <= 1'b1;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			if (cmd.press && fl_ok && (item_fl_q != car_q)) begin
				req_q[item_fl_q[IW-1:0]] <= !rd_bit;
			end
			if (cmd.scan_init) begin
				sdir_q <= dir_q;
				idx_q  <= dir_q ? up_init : dn_init;
				pass_q <= 1'b0;
			end
			if (cmd.scan_flip) begin
				sdir_q <= !sdir_q;
				idx_q  <= sdir_q ? dn_init : up_init;
				pass_q <= 1'b1;
			end
			if (cmd.scan_step) begin
				idx_q <= sdir_q ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
			end
			if (cmd.take) begin
				car_q               <= idx_q[FLOOR_W-1:0];
				req_q[idx_q[IW-1:0]] <= 1'b0;
				dir_q               <= sdir_q;
			end
			if (cmd.miss) begin
				dir_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_func_q <= s_tuser;
			item_fl_q   <= s_tdata[FLOOR_W-1:0];
		end
		if (cmd.press) begin
			if (!fl_ok) begin
				res_status_q <= ST_OUT_RANGE;
			end else if (item_fl_q == car_q) begin
				res_status_q <= ST_EXIT;
			end else if (rd_bit) begin
				res_status_q <= ST_REMOVED;
			end else begin
				res_status_q <= ST_ADDED;
			end
		end
		if (cmd.take) begin
			res_status_q <= ST_ARRIVED;
		end
		if (cmd.miss) begin
			res_status_q <= ST_NONE;
		end
		if (cmd.emit) begin
			out_data_q <= {5'b0, dir_q, car_q, res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

/* bench/tb_elevator_look_scheduler_top.sv */
// Testbench for the LOOK elevator scheduler top level: directed and random items, scoreboard.
`default_nettype none
module tb_elevator_look_scheduler_top;
	import els_pkg::*;

	localparam int  NUM_FLOORS = 128;
	localparam bit  FN_PRESS   = 1'b0;
	localparam bit  FN_RUN     = 1'b1;
	localparam int  REPORT_MAX = 10;

	typedef struct {
		status_t          status;
		logic [FLOOR_W-1:0] car;
		logic             up;
	} car_report_t;

	// Tracks the car, its pending requests and the results still to come back.
	class elevator_scoreboard;
		logic [NUM_FLOORS-1:0] requests;
		logic [FLOOR_W-1:0]    car;
		logic                  up;
		logic [FLOOR_W-1:0]    top;
		car_report_t           awaited_reports[$];
		int                    errors;

		function void clear();
			requests = '0;
			car      = 7'd1;
			up       = 1'b1;
			top      = TOP_FLOOR_RESET;
			awaited_reports.delete();
			errors   = 0;
		endfunction

		function int scan_up();
			int f;
			for (f = car + 1; f <= top && f < NUM_FLOORS; f++) begin
				if (requests[f])
					return f;
			end
			return 0;
		endfunction

		function int scan_down();
			int f;
			for (f = car - 1; f >= 1; f--) begin
				if (requests[f])
					return f;
			end
			return 0;
		endfunction

		function car_report_t predict_item(bit fn, logic [FLOOR_W-1:0] fl);
			car_report_t r;
			int target;
			if (fn == FN_PRESS) begin
				if (fl < 1 || fl > top) begin
					r.status = ST_OUT_RANGE;
				end else if (fl == car) begin
					r.status = ST_EXIT;
				end else if (requests[fl]) begin
					requests[fl] = 1'b0;
					r.status = ST_REMOVED;
				end else begin
					requests[fl] = 1'b1;
					r.status = ST_ADDED;
				end
			end else begin
				if (up) begin
					target = scan_up();
					if (target == 0) begin
						up = 1'b0;
						target = scan_down();
					end
				end else begin
					target = scan_down();
					if (target == 0) begin
						up = 1'b1;
						target = scan_up();
						// Nothing either way leaves the car facing down.
						if (target == 0)
							up = 1'b0;
					end
				end
				if (target != 0) begin
					car = target[FLOOR_W-1:0];
					requests[target] = 1'b0;
					r.status = ST_ARRIVED;
				end else begin
					r.status = ST_NONE;
				end
			end
			r.car = car;
			r.up  = up;
			return r;
		endfunction

		function void note_item(bit fn, logic [FLOOR_W-1:0] fl);
			awaited_reports.push_back(predict_item(fn, fl));
		endfunction

		function void check_result(logic [15:0] data);
			car_report_t e;
			if (awaited_reports.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result transfer: data %h", data);
				return;
			end
			e = awaited_reports.pop_front();
			if (data[2:0] !== e.status || data[9:3] !== e.car || data[10] !== e.up
					|| data[15:11] !== 5'd0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display({"result differs: expected status %0d floor %0d up %0d, ",
						"got status %0d floor %0d up %0d (data %h)"},
						e.status, e.car, e.up, data[2:0], data[9:3], data[10], data);
			end
		endfunction

		function int pending();
			return awaited_reports.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [6:0]  cfg_wdata = 7'd0;

	int send_idle = 33;
	int rcv_idle  = 81;
	bit squeeze_req  = 1'b0;
	bit squeeze_done = 1'b0;

	elevator_scoreboard sb = new();

	elevator_look_scheduler_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_item(s_tuser, s_tdata[6:0]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int hold = 0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				hold = 1500;
				squeeze_done = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// Valid stays high from one item to the next unless idle cycles are drawn.
	task automatic send_item(bit fn, logic [6:0] fl);
		int gap = 0;
		while (gap < 50 && $urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, fl};
		s_tuser  <= fn;
		do @(posedge clk); while (!s_tready);
	endtask

	// The first wait lets the monitor note a transfer made at the edge just passed.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_top(logic [6:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.top = value;
	endtask

	task automatic send_random();
		int r = $urandom_range(99);
		if (r < 33)
			send_item(FN_RUN, 7'($urandom_range(127)));
		else if (r < 43)
			send_item(FN_PRESS, 7'($urandom_range(127)));
		else if (r < 48)
			send_item(FN_PRESS, sb.car);
		else if (sb.top == 0)
			send_item(FN_PRESS, 7'($urandom_range(127)));
		else
			send_item(FN_PRESS, 7'($urandom_range(sb.top, 1)));
	endtask

	initial begin
		logic [6:0] tops[9] = '{7'd127, 7'd1, 7'd0, 7'd15, 7'd127, 7'd6, 7'd127, 7'd40, 7'd127};
		sb.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset value of the top floor.
		send_item(FN_PRESS, 7'd0);
		send_item(FN_PRESS, 7'd127);
		send_item(FN_PRESS, 7'd81);
		send_item(FN_PRESS, 7'd1);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd127);
		send_item(FN_PRESS, 7'd80);
		send_item(FN_PRESS, 7'd5);
		send_item(FN_PRESS, 7'd5);
		send_item(FN_PRESS, 7'd5);
		send_item(FN_PRESS, 7'd40);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd0);
		send_item(FN_PRESS, 7'd80);
		send_item(FN_PRESS, 7'd3);
		send_item(FN_PRESS, 7'd79);
		drain();
		// A request above a lowered top floor is only found looking down.
		write_top(7'd50);
		send_item(FN_PRESS, 7'd20);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd0);
		send_item(FN_RUN, 7'd0);
		send_item(FN_PRESS, 7'd64);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			send_idle = (phase < 3) ? 33 : (phase < 6) ? 81 : 0;
			rcv_idle <= (phase < 3) ? 81 : (phase < 6) ? 33 : 0;
			write_top(tops[phase]);
			if (phase == 6)
				squeeze_req <= 1'b1;
			for (int i = 0; i < 110; i++)
				send_random();
			drain();
		end

		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("elevator_look_scheduler_top: match");
		else
			$display("elevator_look_scheduler_top: mismatch");
		$finish;
	end

	initial begin
		#20000000;
		$display("elevator_look_scheduler_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
sv/els_pkg.sv
sv/els_ctrl.sv
sv/els_dp.sv
sv/elevator_look_scheduler_top.sv
bench/tb_elevator_look_scheduler_top.sv
